>>> hw/rtl/dqc_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared constants, operation codes and the cell control type.
// ----------------------------------------------------------------------------
package dqc_pkg;

	localparam int DATA_W        = 32;
	localparam int OP_W          = 3;
	localparam int CAP_W         = 5;
	localparam int DEPTH_DEFAULT = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
	localparam logic [OP_W-1:0] OP_STATUS     = 3'd4;

	localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

	// Move applied to the whole row of cells for one transaction.
	typedef struct packed {
		logic push_front;  // every cell takes its left neighbor
		logic pop_front;   // every cell takes its right neighbor
		logic push_rear;   // the cell at the count position loads the value
	} cell_ctl_t;

endpackage

>>> hw/rtl/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// Bounded double-ended queue
// Deque of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle and its result appears in the
// output register on the next cycle; a stalled result holds the input side
// only while that register is full. The entries sit in a row of DEPTH cells
// with the front always in the first cell: a front push shifts the row
// toward the rear, a front pop shifts it toward the front, and a rear push
// loads the cell at the count position. The rear value is read from the
// cell at count minus one. The capacity register takes effect on the next
// transaction; zero acts as one and values above DEPTH act as DEPTH.
module bounded_double_ended_queue #(
	parameter int DEPTH = dqc_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dqc_pkg::CAP_W-1:0]          cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [dqc_pkg::OP_W-1:0]           operation,
	input  logic signed [dqc_pkg::DATA_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               success,
	output logic signed [dqc_pkg::DATA_W-1:0]  front_value,
	output logic signed [dqc_pkg::DATA_W-1:0]  rear_value,
	output logic                               is_empty,
	output logic                               is_full
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W = (CNT_W > dqc_pkg::CAP_W) ? CNT_W : dqc_pkg::CAP_W;

	logic [dqc_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_next;
	logic [IDX_W-1:0]          rear_pos;
	logic [CMP_W-1:0]          cap_eff;
	logic                      full_now;
	logic                      full_next;
	logic                      empty_now;
	logic                      accept;
	logic                      ok;
	dqc_pkg::cell_ctl_t        ctl;

	logic [dqc_pkg::DATA_W-1:0] cell_data [DEPTH];
	logic [dqc_pkg::DATA_W-1:0] cell_next [DEPTH];

	logic                       out_valid_q;
	logic                       success_q;
	logic [dqc_pkg::DATA_W-1:0] front_q;
	logic [dqc_pkg::DATA_W-1:0] rear_q;
	logic                       empty_q;
	logic                       full_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(DEPTH)) begin
			cap_eff = CMP_W'(DEPTH);
		end else begin
			cap_eff = CMP_W'(capacity_q);
		end
	end

	assign full_now  = CMP_W'(count_q) >= cap_eff;
	assign empty_now = count_q == '0;

	always_comb begin
		ctl        = '0;
		ok         = 1'b1;
		count_next = count_q;
		case (operation)
			dqc_pkg::OP_PUSH_FRONT: begin
				ok             = !full_now;
				ctl.push_front = accept && !full_now;
				if (!full_now) count_next = count_q + CNT_W'(1);
			end
			dqc_pkg::OP_PUSH_REAR: begin
				ok            = !full_now;
				ctl.push_rear = accept && !full_now;
				if (!full_now) count_next = count_q + CNT_W'(1);
			end
			dqc_pkg::OP_POP_FRONT: begin
				ok            = !empty_now;
				ctl.pop_front = accept && !empty_now;
				if (!empty_now) count_next = count_q - CNT_W'(1);
			end
			dqc_pkg::OP_POP_REAR: begin
				ok = !empty_now;
				if (!empty_now) count_next = count_q - CNT_W'(1);
			end
			default: begin
				// Status requests and the unused codes leave the state as it is.
				ok = 1'b1;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [dqc_pkg::DATA_W-1:0] left_d;
		logic [dqc_pkg::DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end

		dqc_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.advance    (accept),
			.ctl        (ctl),
			.count      (count_q),
			.value      (value),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.data_next  (cell_next[i])
		);
	end

	assign rear_pos  = IDX_W'(count_next - CNT_W'(1));
	assign full_next = CMP_W'(count_next) >= cap_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= dqc_pkg::CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			success_q <= ok;
			empty_q   <= count_next == '0;
			full_q    <= full_next;
			if (count_next == '0) begin
				front_q <= dqc_pkg::EMPTY_VALUE;
				rear_q  <= dqc_pkg::EMPTY_VALUE;
			end else begin
				front_q <= cell_next[0];
				rear_q  <= cell_next[rear_pos];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign success     = success_q;
	assign front_value = front_q;
	assign rear_value  = rear_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;

endmodule

>>> hw/rtl/dqc_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One slot of the shifting row; slot zero holds the front entry.
// ----------------------------------------------------------------------------
module dqc_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                           clk,
	input  logic                           advance,
	input  dqc_pkg::cell_ctl_t             ctl,
	input  logic [CNT_W-1:0]               count,
	input  logic [dqc_pkg::DATA_W-1:0]     value,
	input  logic [dqc_pkg::DATA_W-1:0]     left_data,
	input  logic [dqc_pkg::DATA_W-1:0]     right_data,
	output logic [dqc_pkg::DATA_W-1:0]     data,
	output logic [dqc_pkg::DATA_W-1:0]     data_next
);

	logic [dqc_pkg::DATA_W-1:0] data_q;

	always_comb begin
		data_next = data_q;
		if (ctl.push_front) begin
			data_next = left_data;
		end else if (ctl.pop_front) begin
			data_next = right_data;
		end else if (ctl.push_rear && (count == CNT_W'(IDX))) begin
			data_next = value;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= data_next;
		end
	end

	assign data = data_q;

endmodule
